[rtl/pltm_pkg.sv]
// ----------------------------------------------------------------------------
// PCM level and tear monitor package
// Shared widths, limits and the types passed between the monitor's modules.
// ----------------------------------------------------------------------------
package pltm_pkg;

  localparam int CFG_W    = 4;
  localparam int SAMPLE_W = 16;
  localparam int PEAK_W   = 15;
  localparam int COUNT_W  = 32;

  localparam logic [PEAK_W-1:0]   MAG_MAX    = 15'd32767;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [PEAK_W-1:0]   HOT_LIMIT  = 15'd32000;
  localparam logic signed [SAMPLE_W:0] JUMP_HI = 17'sd32000;
  localparam logic signed [SAMPLE_W:0] JUMP_LO = -17'sd32000;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 32'hFFFF_FFFF;

  // Block totals.
  typedef struct packed {
    logic [PEAK_W-1:0]  peak;
    logic [COUNT_W-1:0] hot;
    logic [COUNT_W-1:0] jumps;
    logic [COUNT_W-1:0] samples;
  } stats_t;

  // One sample's contribution to the totals.
  typedef struct packed {
    logic fire;
    logic last;
    logic hot;
    logic jump;
  } acc_upd_t;

endpackage

[rtl/pltm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pltm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pltm_chan_seq.sv]
// ----------------------------------------------------------------------------
// Channel sequencer
// Holds the channel count register and steps the interleave pointer.
// ----------------------------------------------------------------------------
module pltm_chan_seq
  import pltm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_count_i,
  input  logic             step_i,
  input  logic             last_i,
  output logic [PW-1:0]    ch_o,
  output logic             filled_o
);

  localparam int SW   = $clog2(MAX_CHANNELS + 1);
  localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;
  localparam logic [CMPW-1:0] MAX_EXT = CMPW'(MAX_CHANNELS);
  localparam logic [CMPW-1:0] ONE_EXT = CMPW'(1);

  logic [CFG_W-1:0] count_q, count_d;
  logic [PW-1:0]    ptr_q, ptr_d;
  logic             filled_q, filled_d;

  logic [CMPW-1:0] count_ext, stride, ptr_ext, ch_ext, next_ext;
  logic            wrap;

  always_comb begin
    count_ext = CMPW'(count_q);
    priority if (count_ext == '0) begin
      stride = ONE_EXT;
    end else if (count_ext > MAX_EXT) begin
      stride = MAX_EXT;
    end else begin
      stride = count_ext;
    end
    ptr_ext  = CMPW'(ptr_q);
    ch_ext   = (ptr_ext >= stride) ? '0 : ptr_ext;
    next_ext = ch_ext + ONE_EXT;
    wrap     = (next_ext >= stride);
  end

  assign ch_o     = ch_ext[PW-1:0];
  assign filled_o = filled_q;

  always_comb begin
    count_d  = count_q;
    ptr_d    = ptr_q;
    filled_d = filled_q;
    priority if (cfg_we_i) begin
      count_d  = cfg_count_i;
      ptr_d    = '0;
      filled_d = 1'b0;
    end else if (step_i) begin
      priority if (last_i) begin
        ptr_d    = '0;
        filled_d = 1'b0;
      end else if (wrap) begin
        ptr_d    = '0;
        filled_d = 1'b1;
      end else begin
        ptr_d = next_ext[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CFG_W'(1);
      ptr_q    <= '0;
      filled_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      filled_q <= filled_d;
    end
  end

endmodule

[rtl/pltm_accum.sv]
// ----------------------------------------------------------------------------
// Block accumulator
// Running peak and saturating counters; totals include the current sample.
// ----------------------------------------------------------------------------
module pltm_accum
  import pltm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acc_upd_t          upd_i,
  input  logic [PEAK_W-1:0] mag_i,
  output stats_t            totals_o
);

  stats_t run_q, run_d, totals;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v,
                                                 input logic en);
    logic [COUNT_W-1:0] r;
    r = v;
    if (en && (v != COUNT_MAX)) begin
      r = v + COUNT_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    totals.peak    = (mag_i > run_q.peak) ? mag_i : run_q.peak;
    totals.hot     = sat_inc(run_q.hot, upd_i.hot);
    totals.jumps   = sat_inc(run_q.jumps, upd_i.jump);
    totals.samples = sat_inc(run_q.samples, 1'b1);
    run_d = run_q;
    if (upd_i.fire) begin
      run_d = upd_i.last ? '0 : totals;
    end
  end

  assign totals_o = totals;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

[rtl/pcm_level_and_tear_monitor.sv]
// ----------------------------------------------------------------------------
// PCM level and tear monitor
// A block result is registered into the output register when its last sample
// leaves stage 1. Throughput: one sample per cycle while the input is not
// stalled, limited by the read-modify-write of the channel history RAM, with
// forwarding between consecutive samples of the same channel. The input
// stalls only while a block result waits and another last sample is ready
// to complete. Reset clears the counters, pointer and channel count (to one);
// the history RAM is not cleared; its data is used only after being written.
// ----------------------------------------------------------------------------
module pcm_level_and_tear_monitor
  import pltm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                last_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PEAK_W-1:0]   peak_level_o,
  output logic [COUNT_W-1:0]  hot_count_o,
  output logic [COUNT_W-1:0]  jump_count_o,
  output logic [COUNT_W-1:0]  sample_count_o
);

  localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic cfg_we, in_accept;
  logic [PW-1:0] ch;
  logic hist_filled;

  // Stage 1: sample waiting on the history read.
  logic                s1_valid_q, s1_valid_d;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s1_last_q;
  logic [PW-1:0]       s1_ch_q;
  logic                s1_filled_q;
  logic                fwd_hit_q;
  logic [SAMPLE_W-1:0] fwd_data_q;
  logic                s1_block, s1_fire;

  logic [SAMPLE_W-1:0]   hist_rdata, prev;
  logic signed [SAMPLE_W:0] delta;
  logic [PEAK_W-1:0]     mag;
  acc_upd_t              upd;
  stats_t                totals;

  logic   out_valid_q, out_valid_d;
  stats_t out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  assign s1_block   = s1_valid_q & s1_last_q & out_valid_q & out_stall_i;
  assign s1_fire    = s1_valid_q & ~s1_block;
  assign in_stall_o = s1_block;
  assign in_accept  = in_valid_i & ~in_stall_o;

  pltm_chan_seq #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_count_i(cfg_data_i),
    .step_i     (in_accept),
    .last_i     (last_sample_i),
    .ch_o       (ch),
    .filled_o   (hist_filled)
  );

  pltm_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_CHANNELS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (s1_fire),
    .waddr_i(s1_ch_q),
    .wdata_i(s1_sample_q),
    .re_i   (in_accept),
    .raddr_i(ch),
    .rdata_o(hist_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // The RAM write of the sample in stage 1 lands at the same edge as the
  // next read, so a read of that channel takes the stage 1 sample instead.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_i;
      s1_last_q   <= last_sample_i;
      s1_ch_q     <= ch;
      s1_filled_q <= hist_filled;
      fwd_hit_q   <= s1_valid_q && (s1_ch_q == ch);
      fwd_data_q  <= s1_sample_q;
    end
  end

  always_comb begin
    prev  = fwd_hit_q ? fwd_data_q : hist_rdata;
    delta = $signed({s1_sample_q[SAMPLE_W-1], s1_sample_q})
          - $signed({prev[SAMPLE_W-1], prev});
    if (s1_sample_q == SAMPLE_MIN) begin
      mag = MAG_MAX;
    end else if (s1_sample_q[SAMPLE_W-1]) begin
      mag = PEAK_W'(-s1_sample_q);
    end else begin
      mag = s1_sample_q[PEAK_W-1:0];
    end
    upd.fire = s1_fire;
    upd.last = s1_last_q;
    upd.hot  = (mag > HOT_LIMIT);
    upd.jump = s1_filled_q && ((delta > JUMP_HI) || (delta < JUMP_LO));
  end

  pltm_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .mag_i   (mag),
    .totals_o(totals)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_q <= totals;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign peak_level_o   = out_q.peak;
  assign hot_count_o    = out_q.hot;
  assign jump_count_o   = out_q.jumps;
  assign sample_count_o = out_q.samples;

  // A result is only captured when the output register is free or draining.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |-> (!out_valid_q || !out_stall_i))
    else $error("block result overwrote a pending result");

  // A blocked stage 1 sample stays in place for the next cycle.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_block) |=> s1_valid_q)
    else $error("blocked sample left stage 1");

  // The sample after a block's last one is never compared with history.
  a_block_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_sample_i) |=> !hist_filled)
    else $error("history still marked filled after end of block");

endmodule
